[hw/rtl/epoch_seconds_to_calendar_date_defines.svh]
// Assertion helpers for the calendar converter.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar converter check failed");

// Next-cycle implication, checked outside reset.
`define ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar converter check failed");

`endif

[hw/rtl/esc_pkg.sv]
package esc_pkg;

  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned YIDX_W   = 8;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned NUM_STAGES = 11;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned DAYS_PER_YEAR = 365;

  localparam logic [STAMP_W-1:0] LAST_STAMP    = 32'd4102444799;
  localparam logic [DAYS_W-1:0]  EPOCH_WEEKDAY = 16'd4;
  localparam logic [11:0]        EPOCH_YEAR    = 12'd1970;
  localparam logic [11:0]        LAST_YEAR     = 12'd2099;
  localparam logic [3:0]         LAST_MONTH    = 4'd12;
  localparam logic [4:0]         LAST_MDAY     = 5'd31;
  localparam logic [4:0]         LAST_HOUR     = 5'd23;
  localparam logic [5:0]         LAST_MINSEC   = 6'd59;
  localparam logic [1:0]         LEAP_PHASE    = 2'd2;

  // Days before the first of each month in a common year.
  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Quotient and remainder widths of the constant dividers.
  function automatic int unsigned cdiv_qw(int unsigned w, int unsigned d);
    return w - $clog2(d + 1) + 1;
  endfunction

  function automatic int unsigned cdiv_rw(int unsigned d);
    return $clog2(d);
  endfunction

  typedef struct packed {
    logic mul;
    logic fix;
  } esc_adv_t;

  typedef struct packed {
    logic              flag;
    logic [5:0]        sec;
    logic [5:0]        min;
    logic [4:0]        hour;
    logic [2:0]        wday;
    logic [YIDX_W-1:0] y;
    logic [DOY_W-1:0]  doy;
    logic              leap;
    logic [3:0]        mon;
    logic [4:0]        mday;
    logic [11:0]       year;
  } esc_side_t;

endpackage

[hw/rtl/esc_if.sv]
interface esc_in_if;
  logic                        valid;
  logic                        ready;
  logic [esc_pkg::STAMP_W-1:0] stamp_seconds;

  modport source (output valid, output stamp_seconds, input ready);
  modport sink (input valid, input stamp_seconds, output ready);
endinterface

interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  second_out;
  logic [5:0]  minute_out;
  logic [4:0]  hour_out;
  logic [2:0]  weekday_out;
  logic [11:0] year_out;
  logic [8:0]  day_of_year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_of_month_out;
  logic        out_of_range;

  modport source (
    output valid, input ready,
    output second_out, output minute_out, output hour_out, output weekday_out,
    output year_out, output day_of_year_out, output month_out,
    output day_of_month_out, output out_of_range
  );
  modport sink (
    input valid, output ready,
    input second_out, input minute_out, input hour_out, input weekday_out,
    input year_out, input day_of_year_out, input month_out,
    input day_of_month_out, input out_of_range
  );
endinterface

[hw/rtl/esc_cdiv.sv]
// Two-stage division by a constant: reciprocal multiply, then one correction step.
module esc_cdiv import esc_pkg::*; #(
  parameter int unsigned W = STAMP_W,
  parameter int unsigned D = SECS_PER_MIN
) (
  input  logic                        clk_i,
  input  esc_adv_t                    adv_i,
  input  logic [W-1:0]                x_i,
  output logic [cdiv_qw(W, D)-1:0]    q_o,
  output logic [cdiv_rw(D)-1:0]       r_o
);

  localparam int unsigned QW = cdiv_qw(W, D);
  localparam int unsigned RW = cdiv_rw(D);
  localparam logic [63:0] MUL_FULL = (64'd1 << W) / 64'(D);
  localparam logic [W-1:0] MUL = MUL_FULL[W-1:0];
  localparam logic [W-1:0] DIV = W'(D);

  logic [2*W-1:0] prod;
  logic [W-1:0]   x_q;
  logic [QW-1:0]  qe_q;
  logic [W-1:0]   qd;
  logic [W-1:0]   rem;
  logic           fix;
  logic [QW-1:0]  q_d, q_q;
  logic [RW-1:0]  r_d, r_q;

  // The estimate is never above the true quotient and at most one below it.
  assign prod = (2*W)'(x_i) * (2*W)'(MUL);

  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      x_q  <= x_i;
      qe_q <= prod[W+QW-1:W];
    end
  end

  assign qd  = W'(qe_q) * DIV;
  assign rem = x_q - qd;
  assign fix = (rem >= DIV);
  assign q_d = qe_q + QW'(fix);
  assign r_d = fix ? RW'(rem - DIV) : RW'(rem);

  always_ff @(posedge clk_i) begin
    if (adv_i.fix) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

[hw/rtl/epoch_seconds_to_calendar_date.sv]
// Throughput: one item per cycle while the output is taken;
// the eleven-stage pipeline holds up to eleven items.
// Each stage has its own valid bit and advances when it is empty or its successor moves,
// so an empty stage is filled even while the output waits.
// Reset clears only the valid bits; the datapath registers are not reset.
`include "epoch_seconds_to_calendar_date_defines.svh"

module epoch_seconds_to_calendar_date import esc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  esc_in_if.sink        in_i,
  esc_out_if.source     out_o
);

  localparam int unsigned NS = NUM_STAGES;

  // Widths of the chained quotients: seconds, then minutes, then hours, then days.
  localparam int unsigned Q1_W = cdiv_qw(STAMP_W, SECS_PER_MIN);
  localparam int unsigned Q2_W = cdiv_qw(Q1_W, MINS_PER_HOUR);
  localparam int unsigned Q3_W = cdiv_qw(Q2_W, HOURS_PER_DAY);

  // Stage map:
  //   1-2   stamp / 60     -> second, total minutes
  //   3-4   minutes / 60   -> minute, total hours
  //   5-6   hours / 24     -> hour, days since the epoch
  //   7-8   days / 365 and (days + 4) / 7 -> year guess, weekday
  //   9     year correction and day of year
  //   10    leap flag and month
  //   11    day of month and calendar year (output register)
  logic [NS:1] v_q;
  logic [NS:1] v_prev;
  logic [NS:1] rdy;
  esc_side_t   side_q [1:NS];
  esc_side_t   side_d [1:NS];

  logic               flag;
  logic [STAMP_W-1:0] stamp_c;

  logic [Q1_W-1:0]    q_sec;
  logic [5:0]         r_sec;
  logic [Q2_W-1:0]    q_min;
  logic [5:0]         r_min;
  logic [Q3_W-1:0]    q_hour;
  logic [4:0]         r_hour;
  logic [DAYS_W-1:0]  days;
  logic [DAYS_W-1:0]  days_wk;
  logic [YIDX_W-1:0]  y0;
  logic [DOY_W-1:0]   r_year;
  logic [2:0]         r_week;

  logic [YIDX_W-1:0]  y0_p1;
  logic [YIDX_W-3:0]  quarter;
  logic [DOY_W:0]     doy_back;
  logic               leap10;
  logic [3:0]         mon_cnt;
  logic [DOY_W-1:0]   thr;
  logic [3:0]         mon_idx;
  logic [DOY_W-1:0]   mon_start;

  logic               out_last_moment;
  logic               out_date_ok;

  // Ready ripples back from the output: a stage can take new data when it is
  // empty or when its content moves on in the same cycle.
  always_comb begin
    rdy[NS] = !v_q[NS] || out_o.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready = rdy[1];
  assign v_prev     = {v_q[NS-1:1], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_prev[k];
        end
      end
    end
  end

  // Stamps past the last second of 2099 are clamped to it and flagged.
  assign flag    = (in_i.stamp_seconds > LAST_STAMP);
  assign stamp_c = flag ? LAST_STAMP : in_i.stamp_seconds;

  esc_cdiv #(.W(STAMP_W), .D(SECS_PER_MIN)) u_div_sec (
    .clk_i (clk_i),
    .adv_i ('{mul: rdy[1], fix: rdy[2]}),
    .x_i   (stamp_c),
    .q_o   (q_sec),
    .r_o   (r_sec)
  );

  esc_cdiv #(.W(Q1_W), .D(MINS_PER_HOUR)) u_div_min (
    .clk_i (clk_i),
    .adv_i ('{mul: rdy[3], fix: rdy[4]}),
    .x_i   (q_sec),
    .q_o   (q_min),
    .r_o   (r_min)
  );

  esc_cdiv #(.W(Q2_W), .D(HOURS_PER_DAY)) u_div_hour (
    .clk_i (clk_i),
    .adv_i ('{mul: rdy[5], fix: rdy[6]}),
    .x_i   (q_min),
    .q_o   (q_hour),
    .r_o   (r_hour)
  );

  // After clamping, the day count stays below 47482, so it fits in DAYS_W bits
  // and the weekday offset cannot wrap.
  assign days    = q_hour[DAYS_W-1:0];
  assign days_wk = days + EPOCH_WEEKDAY;

  esc_cdiv #(.W(DAYS_W), .D(DAYS_PER_YEAR)) u_div_year (
    .clk_i (clk_i),
    .adv_i ('{mul: rdy[7], fix: rdy[8]}),
    .x_i   (days),
    .q_o   (y0),
    .r_o   (r_year)
  );

  esc_cdiv #(.W(DAYS_W), .D(DAYS_PER_WEEK)) u_div_week (
    .clk_i (clk_i),
    .adv_i ('{mul: rdy[7], fix: rdy[8]}),
    .x_i   (days_wk),
    .q_o   (),
    .r_o   (r_week)
  );

  // The year guess days/365 ignores leap days. Days before year y0 are
  // 365*y0 + (y0+1)/4, so the remainder r gives the day of the year directly
  // once the leap days are taken off. When r is smaller than that leap count
  // the guess overshot by exactly one year, and the day of the year becomes
  // r + 365 - y0/4.
  assign y0_p1    = y0 + YIDX_W'(1);
  assign quarter  = y0_p1[YIDX_W-1:2];
  assign doy_back = (DOY_W+1)'(r_year) + (DOY_W+1)'(DAYS_PER_YEAR)
                  - (DOY_W+1)'(y0[YIDX_W-1:2]);

  // Within 1970..2099 every fourth year from 1972 is leap, which is the
  // years whose offset from 1970 leaves two after division by four.
  assign leap10 = (side_q[9].y[1:0] == LEAP_PHASE);

  // The month is one plus the number of month starts already passed.
  always_comb begin
    mon_cnt = 4'd1;
    thr     = '0;
    for (int m = 1; m < 12; m++) begin
      thr = MONTH_START[m] + ((m >= 2) ? DOY_W'(leap10) : '0);
      if (side_q[9].doy >= thr) begin
        mon_cnt = mon_cnt + 4'd1;
      end
    end
  end

  assign mon_idx   = side_q[10].mon - 4'd1;
  assign mon_start = MONTH_START[mon_idx]
                   + DOY_W'((side_q[10].mon >= 4'd3) && side_q[10].leap);

  always_comb begin
    side_d[1]      = '0;
    side_d[1].flag = flag;
    for (int k = 2; k <= NS; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[3].sec  = r_sec;
    side_d[5].min  = r_min;
    side_d[7].hour = r_hour;
    side_d[9].wday = r_week;
    if ((DOY_W+1)'(r_year) >= (DOY_W+1)'(quarter)) begin
      side_d[9].y   = y0;
      side_d[9].doy = r_year - DOY_W'(quarter);
    end else begin
      side_d[9].y   = y0 - YIDX_W'(1);
      side_d[9].doy = doy_back[DOY_W-1:0];
    end
    side_d[10].leap = leap10;
    side_d[10].mon  = mon_cnt;
    side_d[11].mday = 5'(side_q[10].doy - mon_start + DOY_W'(1));
    side_d[11].year = EPOCH_YEAR + 12'(side_q[10].y);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // The last stage is the output register.
  assign out_o.valid            = v_q[NS];
  assign out_o.second_out       = side_q[NS].sec;
  assign out_o.minute_out       = side_q[NS].min;
  assign out_o.hour_out         = side_q[NS].hour;
  assign out_o.weekday_out      = side_q[NS].wday;
  assign out_o.year_out         = side_q[NS].year;
  assign out_o.day_of_year_out  = side_q[NS].doy;
  assign out_o.month_out        = side_q[NS].mon;
  assign out_o.day_of_month_out = side_q[NS].mday;
  assign out_o.out_of_range     = side_q[NS].flag;

  // The offered fields name the last second of 2099.
  assign out_last_moment = (out_o.year_out == LAST_YEAR) && (out_o.month_out == LAST_MONTH)
                        && (out_o.day_of_month_out == LAST_MDAY)
                        && (out_o.hour_out == LAST_HOUR)
                        && (out_o.minute_out == LAST_MINSEC)
                        && (out_o.second_out == LAST_MINSEC);

  // The offered date is a real calendar position within the supported span.
  assign out_date_ok = (out_o.month_out != '0) && (out_o.month_out <= LAST_MONTH)
                    && (out_o.day_of_month_out != '0)
                    && (out_o.year_out >= EPOCH_YEAR) && (out_o.year_out <= LAST_YEAR);

  // An accepted stamp always lands in the first stage.
  `ESC_ASSERT_NEXT(a_accept_fills_first, in_i.valid && in_i.ready, v_q[1])

  // A saturated result describes the last second of 2099.
  `ESC_ASSERT_NOW(a_saturated_moment, out_o.valid && out_o.out_of_range, out_last_moment)

  // Every offered date is a real calendar position within the supported span.
  `ESC_ASSERT_NOW(a_date_in_span, out_o.valid, out_date_ok)

  // The ready chain keeps a full last stage valid while the output stalls.
  `ESC_ASSERT_NEXT(a_last_stage_holds, v_q[NS] && !out_o.ready, v_q[NS])

endmodule
